>>> rtl/core/i2cram_pkg.sv
// shared types and constants for the i2c register access master core
package i2cram_pkg;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [7:0] DEV_ADDR_RESET = 8'h8a;
   localparam logic [7:0] READ_BIT       = 8'h01;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_WRITE,
      OP_READ,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] reg_addr;
      logic [7:0] write_data;
      logic       sda_in;
   } item_type;

endpackage

>>> rtl/core/i2cram_front.sv
// front end: accepts request words, decodes the command and queues them
module i2cram_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_command,
   input  logic [7:0]          req_reg_addr,
   input  logic [7:0]          req_write_data,
   input  logic                req_sda_in,
   output logic                q_valid,
   output i2cram_pkg::item_type q_item,
   input  logic                q_pop
);

   i2cram_pkg::item_type queue_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   i2cram_pkg::item_type item_w;

   always_comb begin
      item_w.reg_addr   = req_reg_addr;
      item_w.write_data = req_write_data;
      item_w.sda_in     = req_sda_in;
      unique case (req_command)
         i2cram_pkg::CMD_TICK:  item_w.op = i2cram_pkg::OP_TICK;
         i2cram_pkg::CMD_WRITE: item_w.op = i2cram_pkg::OP_WRITE;
         i2cram_pkg::CMD_READ:  item_w.op = i2cram_pkg::OP_READ;
         default:               item_w.op = i2cram_pkg::OP_NONE;
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         unique case ({push, q_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
   a_pop_needs_word: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count lost a push");

endmodule

>>> rtl/core/i2cram_back.sv
// back end: sequences the bus phases and holds the result register
module i2cram_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  i2cram_pkg::item_type q_item,
   output logic                q_pop,
   input  logic [7:0]          dev_addr,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_scl_out,
   output logic                rsp_sda_out,
   output logic                rsp_sda_released,
   output logic                rsp_busy_res,
   output logic                rsp_done_res,
   output logic [7:0]          rsp_read_data,
   output logic                rsp_rejected
);

   typedef enum logic [1:0] {
      SEG_START,
      SEG_TX,
      SEG_RX,
      SEG_STOP
   } seg_type;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_FIRST  = 3'd1;
   localparam logic [2:0] PH_SECOND = 3'd2;
   localparam logic [2:0] PH_THIRD  = 3'd3;

   function automatic seg_type seg_kind(input logic is_rd, input logic [2:0] idx);
      seg_type k;
      if (is_rd) begin
         unique case (idx)
            3'd0, 3'd3:       k = SEG_START;
            3'd1, 3'd2, 3'd4: k = SEG_TX;
            3'd5:             k = SEG_RX;
            default:          k = SEG_STOP;
         endcase
      end else begin
         unique case (idx)
            3'd0:             k = SEG_START;
            3'd1, 3'd2, 3'd3: k = SEG_TX;
            default:          k = SEG_STOP;
         endcase
      end
      return k;
   endfunction

   logic [2:0] phase_ff, phase_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [2:0] idx_ff, idx_in;
   logic       rd_ff, rd_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] recv_ff, recv_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       done_w;
   logic       rej_w;
   logic       released_w;
   logic       rsp_valid_ff;
   logic       o_scl_ff, o_sda_ff, o_rel_ff, o_busy_ff, o_done_ff, o_rej_ff;
   logic [7:0] o_data_ff;
   seg_type    kind_w;
   logic [7:0] tx_byte_w;
   logic       tx_bit_w;
   logic [7:0] shifted_w;

   assign q_pop  = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign kind_w = seg_kind(rd_ff, idx_ff);

   always_comb begin
      if (idx_ff == 3'd1) begin
         tx_byte_w = dev_addr;
      end else if (idx_ff == 3'd2) begin
         tx_byte_w = addr_ff;
      end else if (rd_ff) begin
         tx_byte_w = dev_addr | i2cram_pkg::READ_BIT;
      end else begin
         tx_byte_w = data_ff;
      end
   end

   assign tx_bit_w  = tx_byte_w[3'd7 - bit_ff[2:0]];
   assign shifted_w = {shift_ff[6:0], q_item.sda_in};

   always_comb begin
      phase_in = phase_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      idx_in   = idx_ff;
      rd_in    = rd_ff;
      addr_in  = addr_ff;
      data_in  = data_ff;
      recv_in  = recv_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      done_w   = 1'b0;
      rej_w    = 1'b0;
      unique case (q_item.op)
         i2cram_pkg::OP_WRITE, i2cram_pkg::OP_READ: begin
            if (phase_ff != PH_IDLE) begin
               rej_w = 1'b1;
            end else begin
               rd_in    = (q_item.op == i2cram_pkg::OP_READ);
               addr_in  = q_item.reg_addr;
               data_in  = q_item.write_data;
               shift_in = 8'd0;
               idx_in   = 3'd0;
               bit_in   = 4'd0;
               phase_in = PH_FIRST;
            end
         end
         i2cram_pkg::OP_TICK: begin
            if (phase_ff != PH_IDLE) begin
               unique case (kind_w)
                  SEG_START: begin
                     priority case (phase_ff)
                        PH_FIRST:  sda_in = 1'b1;
                        PH_SECOND: scl_in = 1'b1;
                        PH_THIRD:  sda_in = 1'b0;
                        default:   scl_in = 1'b0;
                     endcase
                     if (phase_ff == PH_FIRST || phase_ff == PH_SECOND ||
                         phase_ff == PH_THIRD) begin
                        phase_in = phase_ff + 3'd1;
                     end else begin
                        idx_in   = idx_ff + 3'd1;
                        bit_in   = 4'd0;
                        phase_in = PH_FIRST;
                     end
                  end
                  SEG_STOP: begin
                     priority case (phase_ff)
                        PH_FIRST: begin
                           sda_in   = 1'b0;
                           phase_in = phase_ff + 3'd1;
                        end
                        PH_SECOND: begin
                           scl_in   = 1'b1;
                           phase_in = phase_ff + 3'd1;
                        end
                        default: begin
                           sda_in   = 1'b1;
                           phase_in = PH_IDLE;
                           bit_in   = 4'd0;
                           idx_in   = 3'd0;
                           done_w   = 1'b1;
                        end
                     endcase
                  end
                  default: begin
                     priority case (phase_ff)
                        PH_FIRST: begin
                           if (bit_ff < 4'd8) begin
                              sda_in = (kind_w == SEG_TX) ? tx_bit_w : 1'b1;
                           end else begin
                              sda_in = (kind_w == SEG_RX);
                           end
                           phase_in = phase_ff + 3'd1;
                        end
                        PH_SECOND: begin
                           scl_in   = 1'b1;
                           phase_in = phase_ff + 3'd1;
                        end
                        default: begin
                           scl_in = 1'b0;
                           if (kind_w == SEG_RX && bit_ff < 4'd8) begin
                              shift_in = shifted_w;
                              if (bit_ff == 4'd7) begin
                                 recv_in = shifted_w;
                              end
                           end
                           if (bit_ff >= 4'd8) begin
                              idx_in   = idx_ff + 3'd1;
                              bit_in   = 4'd0;
                              phase_in = PH_FIRST;
                           end else begin
                              bit_in   = bit_ff + 4'd1;
                              phase_in = PH_FIRST;
                           end
                        end
                     endcase
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   assign released_w = (phase_in != PH_IDLE) && (seg_kind(rd_in, idx_in) == SEG_RX) &&
                       (bit_in < 4'd8) && !(bit_in == 4'd0 && phase_in == PH_FIRST);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_ff       <= 4'd0;
         shift_ff     <= 8'd0;
         idx_ff       <= 3'd0;
         rd_ff        <= 1'b0;
         addr_ff      <= 8'd0;
         data_ff      <= 8'd0;
         recv_ff      <= 8'd0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         phase_ff     <= phase_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         idx_ff       <= idx_in;
         rd_ff        <= rd_in;
         addr_ff      <= addr_in;
         data_ff      <= data_in;
         recv_ff      <= recv_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         o_scl_ff  <= scl_in;
         o_sda_ff  <= sda_in;
         o_rel_ff  <= released_w;
         o_busy_ff <= (phase_in != PH_IDLE);
         o_done_ff <= done_w;
         o_data_ff <= recv_in;
         o_rej_ff  <= rej_w;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_out      = o_scl_ff;
   assign rsp_sda_out      = o_sda_ff;
   assign rsp_sda_released = o_rel_ff;
   assign rsp_busy_res     = o_busy_ff;
   assign rsp_done_res     = o_done_ff;
   assign rsp_read_data    = o_data_ff;
   assign rsp_rejected     = o_rej_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && o_done_ff) |-> !o_busy_ff)
      else $error("done word while still busy");
   a_release_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && o_rel_ff) |-> (o_busy_ff && rd_ff))
      else $error("sda released outside a read");
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && o_rej_ff) |-> (o_busy_ff && !o_done_ff))
      else $error("reject while idle");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(o_data_ff)))
      else $error("result register changed under stall");

endmodule

>>> rtl/core/i2c_register_access_master_core.sv
// top level of the i2c register access master core
//
//  channel  direction  handshake          word
//  req_     in         valid / stall      command, reg_addr, write_data, sda_in
//  rsp_     out        valid / stall      scl, sda, release, busy, done, read data, reject
//  csr_     in         valid / ready      device address byte
//
// each request word yields one response word; one word per cycle sustained while rsp_stall is low
// a request word is decoded into a two-word queue, then taken by the phase sequencer
// the sequencer loads its state and the response register in the same cycle
// rsp_stall holds the response register and backs the queue up into req_stall
// synchronous reset returns the bus to idle with scl and sda high
module i2c_register_access_master_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [7:0] req_reg_addr,
   input  logic [7:0] req_write_data,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl_out,
   output logic       rsp_sda_out,
   output logic       rsp_sda_released,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_read_data,
   output logic       rsp_rejected,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic                 q_valid;
   logic                 q_pop;
   i2cram_pkg::item_type q_item;
   logic [7:0]           dev_addr_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= i2cram_pkg::DEV_ADDR_RESET;
      end else if (csr_valid && csr_ready) begin
         dev_addr_ff <= csr_data;
      end
   end

   i2cram_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_reg_addr   (req_reg_addr),
      .req_write_data (req_write_data),
      .req_sda_in     (req_sda_in),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   i2cram_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .dev_addr         (dev_addr_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl_out      (rsp_scl_out),
      .rsp_sda_out      (rsp_sda_out),
      .rsp_sda_released (rsp_sda_released),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_read_data    (rsp_read_data),
      .rsp_rejected     (rsp_rejected)
   );

endmodule

>>> dv/tb.sv
// testbench for the i2c register access master core: predicts every response word
`timescale 1ns / 100ps

module tb;

   localparam logic [1:0] CMD_NONE   = 2'(i2cram_pkg::OP_NONE);
   localparam int         CYCLE_CAP  = 600000;
   localparam int         PHASE_SIZE = 60;

   typedef enum logic [1:0] {SEG_START, SEG_TX, SEG_RX, SEG_STOP} seg_kind_type;
   typedef enum logic [1:0] {SDA_RANDOM, SDA_HIGH, SDA_LOW} sda_pattern_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       released;
      logic       busy;
      logic       done;
      logic [7:0] rdata;
      logic       rej;
   } bus_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_command = i2cram_pkg::CMD_TICK;
   logic [7:0] req_reg_addr = 8'h00;
   logic [7:0] req_write_data = 8'h00;
   logic       req_sda_in = 1'b1;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_scl_out;
   logic       rsp_sda_out;
   logic       rsp_sda_released;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [7:0] rsp_read_data;
   logic       rsp_rejected;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = 8'h00;

   // predicted bus state
   logic [7:0] dev_addr   = i2cram_pkg::DEV_ADDR_RESET;
   logic [6:0] m_phase    = '0;
   logic [3:0] m_bit      = '0;
   logic [7:0] m_shift    = '0;
   logic [2:0] m_seg      = '0;
   logic       m_read     = 1'b0;
   logic [7:0] m_reg      = '0;
   logic [7:0] m_data     = '0;
   logic [7:0] m_rx       = '0;
   logic       m_scl      = 1'b1;
   logic       m_sda      = 1'b1;

   i2cram_pkg::item_type req_words[$];
   bus_word_type         bus_expect[$];
   i2cram_pkg::item_type next_word;
   bus_word_type         want;

   int  req_gap = 0;
   int  stall_left = 0;
   bit  quiet_mode = 1'b0;
   int  words_queued = 0;
   int  words_checked = 0;
   int  done_seen = 0;
   int  rejected_seen = 0;
   int  settings_used = 1;
   int  fails = 0;
   int  cycles = 0;

   i2c_register_access_master_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_reg_addr     (req_reg_addr),
      .req_write_data   (req_write_data),
      .req_sda_in       (req_sda_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl_out      (rsp_scl_out),
      .rsp_sda_out      (rsp_sda_out),
      .rsp_sda_released (rsp_sda_released),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_read_data    (rsp_read_data),
      .rsp_rejected     (rsp_rejected),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   always #10 clock = ~clock;

   function automatic seg_kind_type seg_of();
      if (m_read) begin
         case (m_seg)
            3'd0, 3'd3:       return SEG_START;
            3'd1, 3'd2, 3'd4: return SEG_TX;
            3'd5:             return SEG_RX;
            default:          return SEG_STOP;
         endcase
      end
      case (m_seg)
         3'd0:             return SEG_START;
         3'd1, 3'd2, 3'd3: return SEG_TX;
         default:          return SEG_STOP;
      endcase
   endfunction

   function automatic logic [7:0] tx_byte();
      if (m_seg == 3'd1) return dev_addr;
      if (m_seg == 3'd2) return m_reg;
      if (m_read) return dev_addr | i2cram_pkg::READ_BIT;
      return m_data;
   endfunction

   function automatic void next_segment();
      m_seg   = m_seg + 3'd1;
      m_bit   = '0;
      m_phase = 7'd1;
   endfunction

   function automatic logic bus_advance(logic sda_in);
      seg_kind_type kind;
      logic [7:0]   tx;
      kind = seg_of();
      if (kind == SEG_START) begin
         case (m_phase)
            7'd1: m_sda = 1'b1;
            7'd2: m_scl = 1'b1;
            7'd3: m_sda = 1'b0;
            default: begin
               m_scl = 1'b0;
               next_segment();
               return 1'b0;
            end
         endcase
         m_phase = m_phase + 7'd1;
         return 1'b0;
      end
      if (kind == SEG_STOP) begin
         case (m_phase)
            7'd1: m_sda = 1'b0;
            7'd2: m_scl = 1'b1;
            default: begin
               m_sda   = 1'b1;
               m_phase = '0;
               m_bit   = '0;
               m_seg   = '0;
               return 1'b1;
            end
         endcase
         m_phase = m_phase + 7'd1;
         return 1'b0;
      end
      case (m_phase)
         7'd1: begin
            if (m_bit < 4'd8) begin
               tx    = tx_byte();
               m_sda = (kind == SEG_TX) ? tx[3'd7 - m_bit[2:0]] : 1'b1;
            end else begin
               m_sda = (kind == SEG_RX);
            end
            m_phase = m_phase + 7'd1;
         end
         7'd2: begin
            m_scl   = 1'b1;
            m_phase = m_phase + 7'd1;
         end
         default: begin
            m_scl = 1'b0;
            if (kind == SEG_RX && m_bit < 4'd8) begin
               m_shift = {m_shift[6:0], sda_in};
               if (m_bit == 4'd7) m_rx = m_shift;
            end
            m_bit = m_bit + 4'd1;
            if (m_bit >= 4'd9) next_segment();
            else m_phase = 7'd1;
         end
      endcase
      return 1'b0;
   endfunction

   function automatic bus_word_type bus_step(logic [1:0] cmd, logic [7:0] ra, logic [7:0] wd,
                                             logic si);
      bus_word_type w;
      w = '0;
      if (cmd == i2cram_pkg::CMD_WRITE || cmd == i2cram_pkg::CMD_READ) begin
         if (m_phase != 0) begin
            w.rej = 1'b1;
         end else begin
            m_read  = (cmd == i2cram_pkg::CMD_READ);
            m_reg   = ra;
            m_data  = wd;
            m_shift = '0;
            m_seg   = '0;
            m_bit   = '0;
            m_phase = 7'd1;
         end
      end else if (cmd == i2cram_pkg::CMD_TICK && m_phase != 0) begin
         w.done = bus_advance(si);
      end
      w.scl      = m_scl;
      w.sda      = m_sda;
      w.released = m_phase != 0 && seg_of() == SEG_RX && m_bit < 4'd8 &&
                   !(m_bit == 4'd0 && m_phase == 7'd1);
      w.busy     = m_phase != 0;
      w.rdata    = m_rx;
      return w;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, got_val);
         fails++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            bus_expect.push_back(bus_step(req_command, req_reg_addr, req_write_data,
                                          req_sda_in));
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (req_words.size() != 0) begin
            next_word = req_words.pop_front();
            req_valid      <= 1'b1;
            req_command    <= next_word.op;
            req_reg_addr   <= next_word.reg_addr;
            req_write_data <= next_word.write_data;
            req_sda_in     <= next_word.sda_in;
            req_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (bus_expect.size() == 0) begin
               $error("response word with nothing expected");
               fails++;
            end else begin
               want = bus_expect.pop_front();
               check_field("scl_out", want.scl, rsp_scl_out);
               check_field("sda_out", want.sda, rsp_sda_out);
               check_field("sda_released", want.released, rsp_sda_released);
               check_field("busy_res", want.busy, rsp_busy_res);
               check_field("done_res", want.done, rsp_done_res);
               check_field("read_data", want.rdata, rsp_read_data);
               check_field("rejected", want.rej, rsp_rejected);
               words_checked++;
               if (want.done) done_seen++;
               if (want.rej) rejected_seen++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic push_word(logic [1:0] cmd, logic [7:0] ra, logic [7:0] wd, logic si);
      i2cram_pkg::item_type it;
      it.op         = i2cram_pkg::op_type'(cmd);
      it.reg_addr   = ra;
      it.write_data = wd;
      it.sda_in     = si;
      req_words.push_back(it);
      words_queued++;
   endtask

   task automatic push_noise();
      push_word(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom), 1'($urandom));
   endtask

   task automatic push_ticks(int n, sda_pattern_type pat, bit noisy);
      logic si;
      for (int i = 0; i < n; i++) begin
         if (noisy && $urandom_range(0, 19) == 0) push_noise();
         si = (pat == SDA_RANDOM) ? 1'($urandom) : (pat == SDA_HIGH);
         push_word(i2cram_pkg::CMD_TICK, 8'($urandom), 8'($urandom), si);
      end
   endtask

   task automatic push_transfer(logic rd, logic [7:0] ra, logic [7:0] wd,
                                sda_pattern_type pat, bit noisy);
      int n;
      n = rd ? 119 : 88;
      // broken sequence: cut the ticks short, the next start then lands while busy
      if (noisy && $urandom_range(0, 3) == 0) n = $urandom_range(1, n - 1);
      push_word(rd ? i2cram_pkg::CMD_READ : i2cram_pkg::CMD_WRITE, ra, wd, 1'($urandom));
      push_ticks(n, pat, noisy);
   endtask

   task automatic drain_bus();
      forever begin
         while (req_words.size() != 0 || req_valid || bus_expect.size() != 0)
            @(posedge clock);
         if (m_phase == 0) break;
         push_ticks(8, SDA_RANDOM, 1'b0);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_dev_addr(logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      dev_addr = value;
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      logic [7:0] settings[5];
      int         start_count;
      settings = '{8'h00, 8'hfe, 8'h8a, 8'h00, 8'hfe};
      settings[2] = 8'($urandom_range(0, 254));
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // idle corners, start while busy, unknown command
      push_word(i2cram_pkg::CMD_TICK, 8'hff, 8'hff, 1'b0);
      push_word(CMD_NONE, 8'hff, 8'hff, 1'b1);
      push_word(i2cram_pkg::CMD_WRITE, 8'hff, 8'h00, 1'b0);
      push_ticks(3, SDA_HIGH, 1'b0);
      push_word(i2cram_pkg::CMD_READ, 8'h00, 8'hff, 1'b1);
      push_word(i2cram_pkg::CMD_WRITE, 8'h00, 8'hff, 1'b0);
      push_word(CMD_NONE, 8'h00, 8'h00, 1'b0);
      push_ticks(85, SDA_LOW, 1'b0);
      push_transfer(1'b1, 8'h00, 8'hff, SDA_HIGH, 1'b0);
      push_transfer(1'b0, 8'h00, 8'hff, SDA_RANDOM, 1'b0);
      push_transfer(1'b1, 8'hff, 8'h00, SDA_LOW, 1'b0);
      drain_bus();

      foreach (settings[p]) begin
         write_dev_addr(settings[p]);
         start_count = words_queued;
         while (words_queued - start_count < PHASE_SIZE) begin
            quiet_mode = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0) push_noise();
            push_transfer(1'($urandom), 8'($urandom), 8'($urandom), SDA_RANDOM,
                          $urandom_range(0, 9) >= 7);
         end
         drain_bus();
         quiet_mode = 1'b0;
      end

      $display("checked %0d response words across %0d device address settings",
               words_checked, settings_used);
      $display("%0d transfers completed, %0d starts refused while busy",
               done_seen, rejected_seen);
      if (fails == 0 && bus_expect.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
